// ----- rtl/core/ppc_pkg.sv -----
`default_nettype none
package ppc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned CountW  = 24;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned VecW    = 20;
  localparam logic [ThrW-1:0]   ThrReset = 15'd11626;
  localparam logic [9:0]        MagGain  = 10'd311;
  localparam int unsigned       MagShift = 9;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_RUN_LEN   = 1'b1
  } reg_addr_e;

  typedef logic signed [SampleW-1:0] trig_t;

  function automatic trig_t cos_lut(input logic [IdxW-1:0] idx);
    trig_t r;
    unique case (idx)
      6'd0: r = -16'sd4613;  6'd1: r = 16'sd32442;  6'd2: r = 16'sd23186;
      6'd3: r = 16'sd23155;  6'd4: r = 16'sd11197;  6'd5: r = 16'sd30796;
      6'd6: r = 16'sd31355;  6'd7: r = 16'sd9520;   6'd8: r = 16'sd3515;
      6'd9: r = 16'sd32579;  6'd10: r = 16'sd28172; 6'd11: r = 16'sd16736;
      6'd12: r = 16'sd18433; 6'd13: r = 16'sd27092; 6'd14: r = 16'sd32733;
      6'd15: r = 16'sd1509;  6'd16: r = -16'sd538;  6'd17: r = 16'sd32764;
      6'd18: r = 16'sd25888; 6'd19: r = 16'sd20088; 6'd20: r = 16'sd14944;
      6'd21: r = 16'sd29162; 6'd22: r = 16'sd32296; 6'd23: r = 16'sd5542;
      6'd24: r = 16'sd7544;  6'd25: r = 16'sd31888; 6'd26: r = 16'sd30037;
      6'd27: r = 16'sd13098; 6'd28: r = 16'sd21662; 6'd29: r = 16'sd24586;
      6'd30: r = 16'sd32666; 6'd31: r = -16'sd2578; 6'd32: r = -16'sd2578;
      6'd33: r = 16'sd32666; 6'd34: r = 16'sd24586; 6'd35: r = 16'sd21662;
      6'd36: r = 16'sd13098; 6'd37: r = 16'sd30037; 6'd38: r = 16'sd31888;
      6'd39: r = 16'sd7544;  6'd40: r = 16'sd5542;  6'd41: r = 16'sd32296;
      6'd42: r = 16'sd29162; 6'd43: r = 16'sd14944; 6'd44: r = 16'sd20088;
      6'd45: r = 16'sd25888; 6'd46: r = 16'sd32764; 6'd47: r = -16'sd538;
      6'd48: r = 16'sd1509;  6'd49: r = 16'sd32733; 6'd50: r = 16'sd27092;
      6'd51: r = 16'sd18433; 6'd52: r = 16'sd16736; 6'd53: r = 16'sd28172;
      6'd54: r = 16'sd32579; 6'd55: r = 16'sd3515;  6'd56: r = 16'sd9520;
      6'd57: r = 16'sd31355; 6'd58: r = 16'sd30796; 6'd59: r = 16'sd11197;
      6'd60: r = 16'sd23155; 6'd61: r = 16'sd23186; 6'd62: r = 16'sd32442;
      default: r = -16'sd4613;
    endcase
    return r;
  endfunction

  function automatic trig_t sin_lut(input logic [IdxW-1:0] idx);
    trig_t r;
    unique case (idx)
      6'd0: r = -16'sd32442; 6'd1: r = -16'sd4613;  6'd2: r = -16'sd23155;
      6'd3: r = 16'sd23186;  6'd4: r = -16'sd30796; 6'd5: r = 16'sd11197;
      6'd6: r = -16'sd9520;  6'd7: r = 16'sd31355;  6'd8: r = -16'sd32579;
      6'd9: r = 16'sd3515;   6'd10: r = -16'sd16736; 6'd11: r = 16'sd28172;
      6'd12: r = -16'sd27092; 6'd13: r = 16'sd18433; 6'd14: r = -16'sd1509;
      6'd15: r = 16'sd32733; 6'd16: r = -16'sd32764; 6'd17: r = -16'sd538;
      6'd18: r = -16'sd20088; 6'd19: r = 16'sd25888; 6'd20: r = -16'sd29162;
      6'd21: r = 16'sd14944; 6'd22: r = -16'sd5542;  6'd23: r = 16'sd32296;
      6'd24: r = -16'sd31888; 6'd25: r = 16'sd7544;  6'd26: r = -16'sd13098;
      6'd27: r = 16'sd30037; 6'd28: r = -16'sd24586; 6'd29: r = 16'sd21662;
      6'd30: r = 16'sd2578;  6'd31: r = 16'sd32666;  6'd32: r = -16'sd32666;
      6'd33: r = -16'sd2578; 6'd34: r = -16'sd21662; 6'd35: r = 16'sd24586;
      6'd36: r = -16'sd30037; 6'd37: r = 16'sd13098; 6'd38: r = -16'sd7544;
      6'd39: r = 16'sd31888; 6'd40: r = -16'sd32296; 6'd41: r = 16'sd5542;
      6'd42: r = -16'sd14944; 6'd43: r = 16'sd29162; 6'd44: r = -16'sd25888;
      6'd45: r = 16'sd20088; 6'd46: r = 16'sd538;    6'd47: r = 16'sd32764;
      6'd48: r = -16'sd32733; 6'd49: r = 16'sd1509;  6'd50: r = -16'sd18433;
      6'd51: r = 16'sd27092; 6'd52: r = -16'sd28172; 6'd53: r = 16'sd16736;
      6'd54: r = -16'sd3515; 6'd55: r = 16'sd32579;  6'd56: r = -16'sd31355;
      6'd57: r = 16'sd9520;  6'd58: r = -16'sd11197; 6'd59: r = 16'sd30796;
      6'd60: r = -16'sd23186; 6'd61: r = 16'sd23155; 6'd62: r = 16'sd4613;
      default: r = 16'sd32442;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/polar_peak_clip_cordic.sv -----
// Channel  | Handshake              | Payload
// in       | in_valid_i/in_ready_o  | sample_real_i, sample_imag_i
// out      | out_valid_o/out_ready_i| pulse_real_o, pulse_imag_o, run_done_o
// config   | APB psel/penable/...   | clip_threshold @0x0, samples_per_run @0x4
//
// One item per cycle sustained while out_ready_i stays high; items pass through the stages
// (fold, five vectoring steps, gain multiply, shift, table/compare, pulse multiply).
// Every stage holds while its successor is full and not draining, so a stall
// propagates back as a plain global enable on a full pipe.
// Reset clears valid bits, the run counter and the registers to their defaults.
`default_nettype none
module polar_peak_clip_cordic
  import ppc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic signed [15:0]  sample_real_i,
  input  wire logic signed [15:0]  sample_imag_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic signed [15:0]  pulse_real_o,
  output      logic signed [15:0]  pulse_imag_o,
  output      logic                run_done_o
);

  localparam int unsigned NStg = 10;

  logic [ThrW-1:0]   thr_q;
  logic [CountW-1:0] run_len_q, cnt_q;
  reg_addr_e         reg_addr;

  assign pready   = 1'b1;
  assign reg_addr = reg_addr_e'(paddr[2]);

  // Decode register writes and reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrReset;
      run_len_q <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_addr)
        REG_THRESHOLD: thr_q     <= pwdata[ThrW-1:0];
        REG_RUN_LEN:   run_len_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_addr)
        REG_THRESHOLD: prdata = {17'd0, thr_q};
        REG_RUN_LEN:   prdata = {8'd0, run_len_q};
        default:       prdata = '0;
      endcase
    end
  end

  // Pipeline state per stage
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;
  logic signed [VecW-1:0] x_q [1:6];
  logic signed [VecW-1:0] y_q [1:6];
  logic [IdxW-1:0]        idx_q [1:6];
  logic                   sw_q [1:8];
  logic                   ni_q [1:8];
  logic                   nq_q [1:8];
  logic [31:0]            msq_q [1:8];
  logic [ThrW-1:0]        th_q [1:8];
  logic                   dn_q [1:NStg];
  logic [IdxW-1:0]        ix7_q, ix8_q;
  logic signed [30:0]     prod7_q;
  logic signed [VecW-1:0] mag8_q;
  logic signed [15:0]     c9_q, s9_q;
  logic signed [VecW:0]   ex9_q;
  logic                   hit9_q;
  logic signed [15:0]     pr10_q, pi10_q;

  // Stall control: a stage advances when its successor is empty or advancing
  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) if (en[k]) vld_q[k] <= vld_q[k-1];
    end
  end

  // Run counter advances on accept; flag rides with the item
  logic [CountW-1:0] cnt_nx;
  logic              last_in;
  assign cnt_nx  = cnt_q + 1'b1;
  assign last_in = (run_len_q != '0) && ({1'b0, cnt_q} + 25'd1 >= {1'b0, run_len_q});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (in_valid_i && in_ready_o) cnt_q <= last_in ? '0 : cnt_nx;
  end

  // Stage 1: fold to first octant and form the exact |z|^2
  logic [16:0] ai, aq;
  assign ai = sample_real_i[15] ? 17'(-$signed({sample_real_i[15], sample_real_i}))
                                : {1'b0, sample_real_i};
  assign aq = sample_imag_i[15] ? 17'(-$signed({sample_imag_i[15], sample_imag_i}))
                                : {1'b0, sample_imag_i};
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[1]   <= VecW'(ai) + VecW'(aq);
      y_q[1]   <= (ai <= aq) ? VecW'(ai) - VecW'(aq) : VecW'(aq) - VecW'(ai);
      sw_q[1]  <= (ai <= aq);
      ni_q[1]  <= sample_real_i[15];
      nq_q[1]  <= sample_imag_i[15];
      idx_q[1] <= IdxW'(1);
      th_q[1]  <= thr_q;
      dn_q[1]  <= last_in;
      msq_q[1] <= 32'(sample_real_i * sample_real_i)
                + 32'(sample_imag_i * sample_imag_i);
    end
  end

  // Stages 2..6: one vectoring step each
  for (genvar s = 1; s <= 5; s++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        if (!y_q[s][VecW-1]) begin
          idx_q[s+1] <= idx_q[s] + IdxW'(1 << s);
          x_q[s+1]   <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1]   <= y_q[s] - (x_q[s] >>> s);
        end else begin
          idx_q[s+1] <= idx_q[s];
          x_q[s+1]   <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1]   <= y_q[s] + (x_q[s] >>> s);
        end
        sw_q[s+1]  <= sw_q[s];
        ni_q[s+1]  <= ni_q[s];
        nq_q[s+1]  <= nq_q[s];
        th_q[s+1]  <= th_q[s];
        dn_q[s+1]  <= dn_q[s];
        msq_q[s+1] <= msq_q[s];
      end
    end
  end

  // Stage 7: gain multiply; stage 8: shift to magnitude
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      prod7_q   <= 31'(x_q[6] * $signed({1'b0, MagGain}));
      ix7_q     <= idx_q[6];
      sw_q[7] <= sw_q[6]; ni_q[7] <= ni_q[6]; nq_q[7] <= nq_q[6];
      th_q[7] <= th_q[6]; dn_q[7] <= dn_q[6]; msq_q[7] <= msq_q[6];
    end
    if (en[7]) begin
      mag8_q  <= VecW'(prod7_q >>> MagShift);
      ix8_q   <= ix7_q;
      sw_q[8] <= sw_q[7]; ni_q[8] <= ni_q[7]; nq_q[8] <= nq_q[7];
      th_q[8] <= th_q[7]; dn_q[8] <= dn_q[7]; msq_q[8] <= msq_q[7];
    end
  end

  // Stage 9: table pick, octant fix-up, threshold compare
  trig_t c_raw, s_raw, c_sel, s_sel;
  assign c_raw = cos_lut(ix8_q);
  assign s_raw = sin_lut(ix8_q);
  assign c_sel = sw_q[8] ? s_raw : c_raw;
  assign s_sel = sw_q[8] ? c_raw : s_raw;
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      c9_q   <= ni_q[8] ? -c_sel : c_sel;
      s9_q   <= nq_q[8] ? -s_sel : s_sel;
      ex9_q  <= (VecW+1)'(mag8_q) - $signed({(VecW+1-ThrW)'(0), th_q[8]});
      hit9_q <= msq_q[8] > 32'(th_q[8] * th_q[8]);
      dn_q[9] <= dn_q[8];
    end
  end

  // Stage 10: pulse multiply, keep low 16 bits
  logic signed [36:0] pr_full, pi_full;
  assign pr_full = c9_q * ex9_q;
  assign pi_full = s9_q * ex9_q;
  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      pr10_q   <= hit9_q ? pr_full[15:0] : '0;
      pi10_q   <= hit9_q ? pi_full[15:0] : '0;
      dn_q[10] <= dn_q[9];
    end
  end

  assign pulse_real_o = pr10_q;
  assign pulse_imag_o = pi10_q;
  assign run_done_o   = dn_q[10];

  // Output held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_real_o))
    else $error("output changed under stall");
  // Counter restarts after a flagged item
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_in |=> cnt_q == '0)
    else $error("run counter did not restart");
  // Ready follows downstream when pipe is full
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("accepted into full stalled pipe");
  // Zero pulse when at or below threshold
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[9] && vld_q[8] && !hit9_q |=> pulse_real_o == '0 && pulse_imag_o == '0)
    else $error("pulse under threshold");

endmodule
`default_nettype wire
